>>> hdl/tlqe_pkg.sv
// Package for the thick line quad expander.
// Holds the segment and quad payload types, the pipeline carry types and
// the width-to-thickness table. No dependencies.
package tlqe_pkg;

	localparam int SQ_STEPS  = 32;
	localparam int DIV_STEPS = 16;

	localparam logic [16:0] K_LO    = 17'd27145;
	localparam logic [17:0] K_HI    = 18'd158217;
	localparam logic [12:0] C_TENTH = 13'd6554;
	localparam logic [15:0] C_DIAG  = 16'd46341;
	localparam logic [24:0] D_MIN   = 25'd3;
	localparam logic [15:0] W_ONE   = 16'd256;
	localparam logic [15:0] W_SNAP  = 16'd768;

	localparam logic signed [25:0] Q_MAX = 26'sd8388607;
	localparam logic signed [25:0] Q_MIN = -26'sd8388608;

	typedef struct packed {
		logic signed [23:0] start_x;
		logic signed [23:0] start_y;
		logic signed [23:0] end_x;
		logic signed [23:0] end_y;
		logic [15:0]        line_width;
	} seg_t;

	typedef struct packed {
		logic signed [23:0] corner0_x;
		logic signed [23:0] corner0_y;
		logic signed [23:0] corner1_x;
		logic signed [23:0] corner1_y;
		logic signed [23:0] corner2_x;
		logic signed [23:0] corner2_y;
		logic signed [23:0] corner3_x;
		logic signed [23:0] corner3_y;
	} quad_t;

	typedef struct packed {
		logic signed [23:0] sx;
		logic signed [23:0] sy;
		logic signed [23:0] ex;
		logic signed [23:0] ey;
		logic signed [20:0] fox;
		logic signed [20:0] foy;
		logic               exact;
		logic               neg_dx;
		logic               neg_dy;
		logic [47:0]        ta;
		logic [47:0]        tb;
	} carry_t;

	typedef struct packed {
		carry_t      c;
		logic [63:0] rad;
		logic [32:0] rem;
		logic [31:0] root;
	} sq_t;

	typedef struct packed {
		carry_t      c;
		logic [32:0] d;
		logic [47:0] rem_ox;
		logic [47:0] rem_oy;
		logic [15:0] q_ox;
		logic [15:0] q_oy;
	} dv_t;

	function automatic logic [22:0] t_from_width(input logic [15:0] w);
		logic [16:0] base;
		logic [15:0] slope;
		logic [23:0] prod;
		logic [23:0] wide;
		logic [22:0] t;
		base  = 17'd0;
		slope = 16'd0;
		prod  = 24'd0;
		wide  = 24'({w, 7'b0}) - 24'd32768;
		case (w[15:8])
			8'd0: begin base = 17'd3277;   slope = 16'd0;     end
			8'd1: begin base = 17'd3277;   slope = 16'd21628; end
			8'd2: begin base = 17'd24904;  slope = 16'd38011; end
			8'd3: begin base = 17'd62915;  slope = 16'd31457; end
			8'd4: begin base = 17'd94372;  slope = 16'd30147; end
			8'd5: begin base = 17'd124518; slope = 16'd39322; end
			default: begin base = 17'd0; slope = 16'd0; end
		endcase
		prod = 24'(slope) * 24'(w[7:0]) + 24'd128;
		if (w[15:8] >= 8'd6)
			t = wide[22:0];
		else
			t = 23'(24'(base) + 24'(prod[23:8]));
		return t;
	endfunction

	function automatic logic [23:0] sat24(input logic signed [25:0] v);
		logic [23:0] r;
		if (v > Q_MAX)
			r = 24'h7FFFFF;
		else if (v < Q_MIN)
			r = 24'h800000;
		else
			r = v[23:0];
		return r;
	endfunction

endpackage

>>> hdl/thick_line_quad_expander.sv
// Top level of the thick line quad expander: a 53-stage pipeline.
// Depends on tlqe_pkg for the payload types, constants and helper functions.
// Takes one segment per clock when not stalled and returns its quad; the depth is
// set by the segment length square root (32 stages, two radicand bits per stage)
// and the two normal-offset dividers (16 stages, one quotient bit per stage). A
// downstream stall freezes the whole pipeline, and the input is stalled only while
// a finished quad waits in the output register, so one transfer per cycle is kept.
module thick_line_quad_expander (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 seg_valid,
	output logic                 seg_stall,
	input  tlqe_pkg::seg_t       seg,
	output logic                 quad_valid,
	input  logic                 quad_stall,
	output tlqe_pkg::quad_t      quad
);

	logic adv;

	logic                 v_s1;
	tlqe_pkg::seg_t       seg_s1;
	logic signed [24:0]   dx_s1;
	logic signed [24:0]   dy_s1;
	logic [22:0]          t_s1;
	logic signed [24:0]   dx_d;
	logic signed [24:0]   dy_d;

	logic                 v_s2;
	tlqe_pkg::seg_t       seg_s2;
	logic [22:0]          t_s2;
	logic [49:0]          sqa_s2;
	logic [49:0]          sqb_s2;
	logic [42:0]          lo_s2;
	logic [42:0]          hi_s2;
	logic signed [24:0]   ny_s2;
	logic [35:0]          t10_s2;
	logic [38:0]          tdg_s2;
	logic [47:0]          ta_s2;
	logic [47:0]          tb_s2;
	logic                 smx_s2;
	logic                 smy_s2;
	logic                 ndx_s2;
	logic                 ndy_s2;
	logic [24:0]          adx_c;
	logic [24:0]          ady_c;
	logic signed [24:0]   ny_c;

	logic [49:0]          sum_c;
	logic [26:0]          tk_c;
	logic [26:0]          skr_c;
	logic [23:0]          s1r_c;
	logic [35:0]          s10r_c;
	logic [38:0]          sdgr_c;
	logic signed [20:0]   sk_c;
	logic signed [20:0]   s1o_c;
	logic signed [20:0]   s10_c;
	logic signed [20:0]   sdg_c;
	logic signed [43:0]   yv_c;
	logic signed [43:0]   lo_c;
	logic signed [43:0]   hi_c;
	logic signed [20:0]   fox_c;
	logic signed [20:0]   foy_c;
	logic                 w_frac_c;
	logic                 w_one_c;

	logic                 v_sq_s [0:tlqe_pkg::SQ_STEPS];
	tlqe_pkg::sq_t        sq_s   [0:tlqe_pkg::SQ_STEPS];
	logic                 v_dv_s [0:tlqe_pkg::DIV_STEPS];
	tlqe_pkg::dv_t        dv_s   [0:tlqe_pkg::DIV_STEPS];

	tlqe_pkg::dv_t        dv_last;
	logic signed [20:0]   ox_c;
	logic signed [20:0]   oy_c;
	logic signed [25:0]   sx_w;
	logic signed [25:0]   sy_w;
	logic signed [25:0]   ex_w;
	logic signed [25:0]   ey_w;
	logic signed [25:0]   ox_w;
	logic signed [25:0]   oy_w;

	logic                 quad_valid_q;
	tlqe_pkg::quad_t      quad_q;

	assign adv        = !(quad_valid_q && quad_stall);
	assign seg_stall  = quad_valid_q && quad_stall;
	assign quad_valid = quad_valid_q;
	assign quad       = quad_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			quad_valid_q <= 1'b0;
			for (int i = 0; i <= tlqe_pkg::SQ_STEPS; i++)
				v_sq_s[i] <= 1'b0;
			for (int i = 0; i <= tlqe_pkg::DIV_STEPS; i++)
				v_dv_s[i] <= 1'b0;
		end else if (adv) begin
			v_s1      <= seg_valid;
			v_s2      <= v_s1;
			v_sq_s[0] <= v_s2;
			for (int i = 1; i <= tlqe_pkg::SQ_STEPS; i++)
				v_sq_s[i] <= v_sq_s[i-1];
			v_dv_s[0] <= v_sq_s[tlqe_pkg::SQ_STEPS];
			for (int i = 1; i <= tlqe_pkg::DIV_STEPS; i++)
				v_dv_s[i] <= v_dv_s[i-1];
			quad_valid_q <= v_dv_s[tlqe_pkg::DIV_STEPS];
		end
	end

	always_comb begin
		dx_d = $signed({seg.end_x[23], seg.end_x}) - $signed({seg.start_x[23], seg.start_x});
		dy_d = $signed({seg.end_y[23], seg.end_y}) - $signed({seg.start_y[23], seg.start_y});
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			seg_s1 <= seg;
			dx_s1  <= dx_d;
			dy_s1  <= dy_d;
			t_s1   <= tlqe_pkg::t_from_width(seg.line_width);
		end
	end

	always_comb begin
		adx_c = dx_s1[24] ? 25'(-dx_s1) : 25'(dx_s1);
		ady_c = dy_s1[24] ? 25'(-dy_s1) : 25'(dy_s1);
		ny_c  = dx_s1[24] ? -dy_s1 : dy_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			seg_s2 <= seg_s1;
			t_s2   <= t_s1;
			sqa_s2 <= 50'(adx_c) * 50'(adx_c);
			sqb_s2 <= 50'(ady_c) * 50'(ady_c);
			lo_s2  <= 43'(adx_c) * 43'(tlqe_pkg::K_LO);
			hi_s2  <= 43'(adx_c) * 43'(tlqe_pkg::K_HI);
			ny_s2  <= ny_c;
			t10_s2 <= 36'(t_s1) * 36'(tlqe_pkg::C_TENTH);
			tdg_s2 <= 39'(t_s1) * 39'(tlqe_pkg::C_DIAG);
			ta_s2  <= 48'(t_s1) * 48'(adx_c);
			tb_s2  <= 48'(t_s1) * 48'(ady_c);
			smx_s2 <= adx_c < tlqe_pkg::D_MIN;
			smy_s2 <= ady_c < tlqe_pkg::D_MIN;
			ndx_s2 <= dx_s1[24];
			ndy_s2 <= dy_s1[24];
		end
	end

	always_comb begin
		sum_c    = sqa_s2 + sqb_s2;
		w_frac_c = (seg_s2.line_width != 16'd0) && (seg_s2.line_width < tlqe_pkg::W_ONE);
		w_one_c  = seg_s2.line_width == tlqe_pkg::W_ONE;
		if (w_frac_c)
			tk_c = 27'({t_s2, 3'b0});
		else if (w_one_c)
			tk_c = 27'(t_s2) * 27'd10;
		else
			tk_c = 27'(t_s2);
		skr_c  = tk_c + 27'd128;
		s1r_c  = 24'(t_s2) + 24'd128;
		s10r_c = t10_s2 + 36'h800000;
		sdgr_c = tdg_s2 + 39'h800000;
		sk_c   = $signed(21'(skr_c[26:8]));
		s1o_c  = $signed(21'(s1r_c[23:8]));
		s10_c  = $signed(21'(s10r_c[35:24]));
		sdg_c  = $signed(21'(sdgr_c[38:24]));
		yv_c   = $signed({{3{ny_s2[24]}}, ny_s2, 16'b0});
		lo_c   = $signed({1'b0, lo_s2});
		hi_c   = $signed({1'b0, hi_s2});
		fox_c  = '0;
		foy_c  = '0;
		if (smx_s2) begin
			fox_c = sk_c;
		end else if (smy_s2) begin
			foy_c = sk_c;
		end else if (yv_c > -lo_c && yv_c <= lo_c) begin
			fox_c = s10_c;
			foy_c = s1o_c;
		end else if (yv_c > lo_c && yv_c <= hi_c) begin
			fox_c = -sdg_c;
			foy_c = sdg_c;
		end else if (yv_c > hi_c || yv_c <= -hi_c) begin
			fox_c = s1o_c;
			foy_c = s10_c;
		end else begin
			fox_c = sdg_c;
			foy_c = sdg_c;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_s[0].c.sx     <= seg_s2.start_x;
			sq_s[0].c.sy     <= seg_s2.start_y;
			sq_s[0].c.ex     <= seg_s2.end_x;
			sq_s[0].c.ey     <= seg_s2.end_y;
			sq_s[0].c.fox    <= fox_c;
			sq_s[0].c.foy    <= foy_c;
			sq_s[0].c.exact  <= !smx_s2 && !smy_s2 && (seg_s2.line_width >= tlqe_pkg::W_SNAP);
			sq_s[0].c.neg_dx <= ndx_s2;
			sq_s[0].c.neg_dy <= ndy_s2;
			sq_s[0].c.ta     <= ta_s2;
			sq_s[0].c.tb     <= tb_s2;
			sq_s[0].rad      <= {sum_c, 14'b0};
			sq_s[0].rem      <= '0;
			sq_s[0].root     <= '0;
		end
	end

	for (genvar j = 0; j < tlqe_pkg::SQ_STEPS; j++) begin : g_sqrt
		logic [34:0] r2;
		logic [34:0] trial;
		logic [34:0] diff;
		logic        ge;
		always_comb begin
			r2    = {sq_s[j].rem, sq_s[j].rad[63:62]};
			trial = {1'b0, sq_s[j].root, 2'b01};
			diff  = r2 - trial;
			ge    = r2 >= trial;
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				sq_s[j+1].c    <= sq_s[j].c;
				sq_s[j+1].rad  <= {sq_s[j].rad[61:0], 2'b0};
				sq_s[j+1].rem  <= ge ? diff[32:0] : r2[32:0];
				sq_s[j+1].root <= {sq_s[j].root[30:0], ge};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dv_s[0].c      <= sq_s[tlqe_pkg::SQ_STEPS].c;
			dv_s[0].d      <= {sq_s[tlqe_pkg::SQ_STEPS].root, 1'b0};
			dv_s[0].rem_ox <= sq_s[tlqe_pkg::SQ_STEPS].c.tb
				+ 48'(sq_s[tlqe_pkg::SQ_STEPS].root);
			dv_s[0].rem_oy <= sq_s[tlqe_pkg::SQ_STEPS].c.ta
				+ 48'(sq_s[tlqe_pkg::SQ_STEPS].root);
			dv_s[0].q_ox   <= '0;
			dv_s[0].q_oy   <= '0;
		end
	end

	for (genvar j = 0; j < tlqe_pkg::DIV_STEPS; j++) begin : g_div
		localparam int SH = tlqe_pkg::DIV_STEPS - 1 - j;
		logic [47:0] cand;
		logic        ge_x;
		logic        ge_y;
		always_comb begin
			cand = 48'(dv_s[j].d) << SH;
			ge_x = dv_s[j].rem_ox >= cand;
			ge_y = dv_s[j].rem_oy >= cand;
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				dv_s[j+1].c      <= dv_s[j].c;
				dv_s[j+1].d      <= dv_s[j].d;
				dv_s[j+1].rem_ox <= ge_x ? dv_s[j].rem_ox - cand : dv_s[j].rem_ox;
				dv_s[j+1].rem_oy <= ge_y ? dv_s[j].rem_oy - cand : dv_s[j].rem_oy;
				dv_s[j+1].q_ox   <= {dv_s[j].q_ox[14:0], ge_x};
				dv_s[j+1].q_oy   <= {dv_s[j].q_oy[14:0], ge_y};
			end
		end
	end

	always_comb begin
		dv_last = dv_s[tlqe_pkg::DIV_STEPS];
		if (dv_last.c.exact) begin
			ox_c = dv_last.c.neg_dy ? $signed(21'(dv_last.q_ox)) : -$signed(21'(dv_last.q_ox));
			oy_c = dv_last.c.neg_dx ? -$signed(21'(dv_last.q_oy)) : $signed(21'(dv_last.q_oy));
		end else begin
			ox_c = dv_last.c.fox;
			oy_c = dv_last.c.foy;
		end
		sx_w = $signed({{2{dv_last.c.sx[23]}}, dv_last.c.sx});
		sy_w = $signed({{2{dv_last.c.sy[23]}}, dv_last.c.sy});
		ex_w = $signed({{2{dv_last.c.ex[23]}}, dv_last.c.ex});
		ey_w = $signed({{2{dv_last.c.ey[23]}}, dv_last.c.ey});
		ox_w = $signed({{5{ox_c[20]}}, ox_c});
		oy_w = $signed({{5{oy_c[20]}}, oy_c});
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			quad_q.corner0_x <= tlqe_pkg::sat24(sx_w - ox_w);
			quad_q.corner0_y <= tlqe_pkg::sat24(sy_w - oy_w);
			quad_q.corner1_x <= tlqe_pkg::sat24(ex_w - ox_w);
			quad_q.corner1_y <= tlqe_pkg::sat24(ey_w - oy_w);
			quad_q.corner2_x <= tlqe_pkg::sat24(sx_w + ox_w);
			quad_q.corner2_y <= tlqe_pkg::sat24(sy_w + oy_w);
			quad_q.corner3_x <= tlqe_pkg::sat24(ex_w + ox_w);
			quad_q.corner3_y <= tlqe_pkg::sat24(ey_w + oy_w);
		end
	end

	a_root_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(v_sq_s[tlqe_pkg::SQ_STEPS] && sq_s[tlqe_pkg::SQ_STEPS].c.exact)
		|-> (sq_s[tlqe_pkg::SQ_STEPS].root != '0))
		else $error("Square root of a long segment is zero.");

	a_root_rem: assert property (@(posedge clk) disable iff (!arst_n)
		v_sq_s[tlqe_pkg::SQ_STEPS]
		|-> (sq_s[tlqe_pkg::SQ_STEPS].rem <= {sq_s[tlqe_pkg::SQ_STEPS].root, 1'b0}))
		else $error("Square root remainder exceeds twice the root.");

	a_quot_range: assert property (@(posedge clk) disable iff (!arst_n)
		(v_dv_s[tlqe_pkg::DIV_STEPS] && dv_last.c.exact)
		|-> (!dv_last.q_ox[15] && !dv_last.q_oy[15]))
		else $error("Normal offset quotient out of range.");

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(v_dv_s[tlqe_pkg::DIV_STEPS] && dv_last.c.exact)
		|-> (dv_last.rem_ox < 48'(dv_last.d) && dv_last.rem_oy < 48'(dv_last.d)))
		else $error("Divider remainder not below the divisor.");

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for thick_line_quad_expander: random and directed segments,
// with quads predicted in the testbench and compared in order of arrival.
// Depends on tlqe_pkg for the segment and quad payload types.
module tb;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 80;

	logic            clk;
	logic            arst_n;
	logic            seg_valid;
	logic            seg_stall;
	tlqe_pkg::seg_t  seg;
	logic            quad_valid;
	logic            quad_stall;
	tlqe_pkg::quad_t quad;

	tlqe_pkg::seg_t  pending_segs[$];
	tlqe_pkg::quad_t expected_quads[$];
	int    segs_sent;
	int    quads_seen = 0;
	int    errors = 0;
	int    idle_cycles = 0;

	thick_line_quad_expander i_dut (
		.clk(clk), .arst_n(arst_n),
		.seg_valid(seg_valid), .seg_stall(seg_stall), .seg(seg),
		.quad_valid(quad_valid), .quad_stall(quad_stall), .quad(quad)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	function automatic longint unsigned root_floor(input longint unsigned v);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic longint scaled_half(input longint unsigned t, input longint unsigned c);
		return longint'((t * c + (64'd1 << 23)) >> 24);
	endfunction

	function automatic logic [23:0] clamp_q8(input longint v);
		if (v < -64'sd8388608)
			v = -64'sd8388608;
		if (v > 64'sd8388607)
			v = 64'sd8388607;
		return v[23:0];
	endfunction

	function automatic tlqe_pkg::quad_t expand_segment(input tlqe_pkg::seg_t s);
		longint sx, sy, ex, ey, dx, dy, ox, oy, nx, ny, yv, lo, hi;
		longint unsigned w, f, t, k, adx, ady, len, mx, my;
		tlqe_pkg::quad_t q;
		sx = s.start_x;
		sy = s.start_y;
		ex = s.end_x;
		ey = s.end_y;
		w  = s.line_width;
		f  = w & 255;
		dx = ex - sx;
		dy = ey - sy;
		adx = dx < 0 ? -dx : dx;
		ady = dy < 0 ? -dy : dy;
		ox = 0;
		oy = 0;
		case (w >> 8)
			0: t = 3277;
			1: t = 3277 + ((21628 * f + 128) >> 8);
			2: t = 24904 + ((38011 * f + 128) >> 8);
			3: t = 62915 + ((31457 * f + 128) >> 8);
			4: t = 94372 + ((30147 * f + 128) >> 8);
			5: t = 124518 + ((39322 * f + 128) >> 8);
			default: t = 163840 + (w - 1536) * 128;
		endcase
		if (w > 0 && w < 256)
			k = 8 * 65536;
		else if (w == 256)
			k = 10 * 65536;
		else
			k = 65536;
		if (adx < 3) begin
			ox = scaled_half(t, k);
		end else if (ady < 3) begin
			oy = scaled_half(t, k);
		end else if (w < 768) begin
			nx = dx < 0 ? -dx : dx;
			ny = dx < 0 ? -dy : dy;
			yv = ny * 65536;
			lo = 27145 * nx;
			hi = 158217 * nx;
			if (yv > -lo && yv <= lo) begin
				ox = scaled_half(t, 6554);
				oy = scaled_half(t, 65536);
			end else if (yv > lo && yv <= hi) begin
				ox = -scaled_half(t, 46341);
				oy = scaled_half(t, 46341);
			end else if (yv > hi || yv <= -hi) begin
				ox = scaled_half(t, 65536);
				oy = scaled_half(t, 6554);
			end else begin
				ox = scaled_half(t, 46341);
				oy = scaled_half(t, 46341);
			end
		end else begin
			len = root_floor((adx * adx + ady * ady) << 14);
			if (len == 0)
				len = 1;
			mx = (t * ady + len) / (2 * len);
			my = (t * adx + len) / (2 * len);
			ox = dy < 0 ? longint'(mx) : -longint'(mx);
			oy = dx < 0 ? -longint'(my) : longint'(my);
		end
		q.corner0_x = clamp_q8(sx - ox);
		q.corner0_y = clamp_q8(sy - oy);
		q.corner1_x = clamp_q8(ex - ox);
		q.corner1_y = clamp_q8(ey - oy);
		q.corner2_x = clamp_q8(sx + ox);
		q.corner2_y = clamp_q8(sy + oy);
		q.corner3_x = clamp_q8(ex + ox);
		q.corner3_y = clamp_q8(ey + oy);
		return q;
	endfunction

	function automatic logic [15:0] pick_width();
		case ($urandom_range(7))
			0: return 16'd0;
			1: return 16'($urandom_range(255, 1));
			2: return 16'd256;
			3: return 16'($urandom_range(767, 257));
			4: return 16'($urandom_range(1535, 768));
			5: return 16'($urandom_range(2560, 1536));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic int pick_delta();
		case ($urandom_range(5))
			0: return $urandom_range(6) - 3;
			1: return $urandom_range(64) - 32;
			2: return $urandom_range(8000) - 4000;
			default: return int'({{8{1'b0}}, 24'($urandom)}) - 8388608;
		endcase
	endfunction

	function automatic tlqe_pkg::seg_t pick_segment();
		tlqe_pkg::seg_t s;
		int dx, dy;
		s.start_x = 24'($urandom);
		s.start_y = 24'($urandom);
		if ($urandom_range(3) == 0) begin
			s.end_x = 24'($urandom);
			s.end_y = 24'($urandom);
		end else begin
			dx = pick_delta();
			dy = pick_delta();
			s.end_x = 24'(int'(s.start_x) + dx);
			s.end_y = 24'(int'(s.start_y) + dy);
		end
		s.line_width = pick_width();
		return s;
	endfunction

	function automatic tlqe_pkg::seg_t make_segment(input int sx, input int sy, input int ex,
			input int ey, input int w);
		tlqe_pkg::seg_t s;
		s.start_x = 24'(sx);
		s.start_y = 24'(sy);
		s.end_x = 24'(ex);
		s.end_y = 24'(ey);
		s.line_width = 16'(w);
		return s;
	endfunction

	function automatic int sender_idle_pct(input int n);
		if (n < 500 || n >= 1500)
			return (n >= 1500) ? 15 : 0;
		return (n < 1000) ? 82 : 0;
	endfunction

	function automatic int receiver_stall_pct(input int n);
		if (n < 1000)
			return 0;
		return (n < 1500) ? 82 : 15;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_valid <= 1'b0;
			seg <= '0;
			segs_sent <= 0;
		end else if (!seg_valid || !seg_stall) begin
			if (pending_segs.size() > 0 && $urandom_range(99) >= sender_idle_pct(segs_sent)) begin
				seg <= pending_segs.pop_front();
				seg_valid <= 1'b1;
				segs_sent <= segs_sent + 1;
			end else begin
				seg_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			quad_stall <= 1'b0;
		else
			quad_stall <= $urandom_range(99) < receiver_stall_pct(quads_seen);
	end

	always @(posedge clk) begin
		logic [7:0][23:0] got_f, exp_f;
		tlqe_pkg::quad_t exp_q;
		if (arst_n) begin
			if (seg_valid && !seg_stall)
				expected_quads.push_back(expand_segment(seg));
			if (quad_valid && !quad_stall) begin
				quads_seen <= quads_seen + 1;
				if (expected_quads.size() == 0) begin
					$display("%0t: quad transfer with no segment outstanding: %h", $realtime, quad);
					errors = errors + 1;
				end else begin
					exp_q = expected_quads.pop_front();
					exp_f = exp_q;
					got_f = quad;
					for (int i = 7; i >= 0; i--) begin
						if (got_f[i] !== exp_f[i]) begin
							$display("%0t: quad field %0d expected %h actual %h", $realtime,
								7 - i, exp_f[i], got_f[i]);
							errors = errors + 1;
						end
					end
				end
			end
			if ((seg_valid && !seg_stall) || (quad_valid && !quad_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
		end
	end

	always @(posedge clk) begin
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		pending_segs.push_back(make_segment(0, 0, 0, 0, 0));
		pending_segs.push_back(make_segment(100, 100, 100, 100, 128));
		pending_segs.push_back(make_segment(0, 0, 2, 5000, 256));
		pending_segs.push_back(make_segment(0, 0, 5000, -2, 255));
		pending_segs.push_back(make_segment(0, 0, 5000, 100, 600));
		pending_segs.push_back(make_segment(0, 0, 5000, 5000, 600));
		pending_segs.push_back(make_segment(0, 0, 100, 5000, 767));
		pending_segs.push_back(make_segment(0, 0, 5000, -5000, 500));
		pending_segs.push_back(make_segment(0, 0, 65536, 27145, 700));
		pending_segs.push_back(make_segment(0, 0, 65536, -27145, 700));
		pending_segs.push_back(make_segment(0, 0, 65536, 158217, 700));
		pending_segs.push_back(make_segment(0, 0, 65536, -158217, 700));
		pending_segs.push_back(make_segment(0, 0, -65536, 27145, 300));
		pending_segs.push_back(make_segment(0, 0, 3000, 4000, 768));
		pending_segs.push_back(make_segment(-7, 9, 3, -3, 1536));
		pending_segs.push_back(make_segment(8388607, 8388607, -8388608, -8388608, 65535));
		pending_segs.push_back(make_segment(-8388608, 8388607, 8388607, -8388608, 65535));
		pending_segs.push_back(make_segment(8388607, -8388608, 8388607, 8388607, 65535));
		pending_segs.push_back(make_segment(-8388608, 0, 8388607, 0, 40000));
		pending_segs.push_back(make_segment(8388600, -8388600, 8388000, -8380000, 1000));
		pending_segs.push_back(make_segment(-1, -1, -8388608, 8388607, 65280));
		for (int i = 0; i < 1880; i++)
			pending_segs.push_back(pick_segment());
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		do
			@(negedge clk);
		while (pending_segs.size() != 0 || seg_valid || expected_quads.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (errors == 0 && expected_quads.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule

>>> thick_line_quad_expander.f
hdl/tlqe_pkg.sv
hdl/thick_line_quad_expander.sv
tb/sv/tb.sv
